// ----- src/rff_pkg.sv -----
package rff_pkg;

	localparam int MAX_DATA_BITS = 8;
	localparam int BAUDOT_BITS   = 5;
	localparam int SYM_W         = 4;
	localparam logic [7:0]  CODE_LETS  = 8'h1F;
	localparam logic [7:0]  CODE_FIGS  = 8'h1B;
	localparam logic [7:0]  CODE_SPACE = 8'h04;
	localparam logic [7:0]  CODE_NUL   = 8'h00;
	localparam logic [13:0] TONE_MAX   = 14'd9000;

	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_EMPTY = 2'd1,
		OP_TUNE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_DATA_BITS   = 3'd0,
		REG_ORDER_POL   = 3'd1,
		REG_PARITY_MODE = 3'd2,
		REG_PREAMBLE    = 3'd3,
		REG_BIT_LEN     = 3'd4,
		REG_STOP_LEN    = 3'd5,
		REG_CENTER_FREQ = 3'd6,
		REG_SHIFT       = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		PAR_NONE = 3'd0,
		PAR_EVEN = 3'd1,
		PAR_ODD  = 3'd2,
		PAR_ZERO = 3'd3,
		PAR_ONE  = 3'd4
	} parity_t;

	typedef enum logic [1:0] {
		JOB_TONE  = 2'd0,
		JOB_STOP  = 2'd1,
		JOB_FRAME = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic [3:0]  data_bits;
		logic [1:0]  order_polarity;
		logic [2:0]  parity_mode;
		logic [7:0]  preamble_len;
		logic [15:0] bit_len;
		logic [15:0] stop_len;
		logic [11:0] center_freq;
		logic [9:0]  shift;
	} cfg_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       two;
		logic [7:0] code0;
		logic [7:0] code1;
		logic       taken;
	} job_t;

	function automatic logic [SYM_W-1:0] eff_bits(input logic [3:0] db);
		if (db < 4'(BAUDOT_BITS))
			return SYM_W'(BAUDOT_BITS);
		else if (db > 4'(MAX_DATA_BITS))
			return SYM_W'(MAX_DATA_BITS);
		else
			return db;
	endfunction

endpackage

// ----- src/rff_in_if.sv -----
interface rff_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] code;
	logic       in_letters;
	logic       in_figures;
	logic       is_space;
	logic       stop_requested;

	modport source(output valid, op, code, in_letters, in_figures, is_space, stop_requested,
		input ready);
	modport sink(input valid, op, code, in_letters, in_figures, is_space, stop_requested,
		output ready);
endinterface

// ----- src/rff_out_if.sv -----
interface rff_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] tone_half_hz;
	logic [15:0] duration;
	logic        char_taken;
	logic        finished;
	logic        last;

	modport source(output valid, tone_half_hz, duration, char_taken, finished, last,
		input ready);
	modport sink(input valid, tone_half_hz, duration, char_taken, finished, last,
		output ready);
endinterface

// ----- src/rff_cfg_if.sv -----
interface rff_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- src/rff_front.sv -----
module rff_front import rff_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pre_load,
	input  logic [7:0] pre_value,
	input  logic       q_full,
	rff_in_if.sink     poll,
	output logic       push,
	output job_t       push_job
);

	logic       shift_state_q;
	logic [7:0] preamble_left_q;
	logic       accept;
	logic       baudot;
	logic       is_tune;
	logic       is_empty;
	logic       ok;
	logic       next_shift;
	logic       shift_upd;
	logic       dec_pre;

	assign poll.ready = !q_full;
	assign accept     = poll.valid && poll.ready;
	assign baudot     = (eff_bits(cfg.data_bits) == SYM_W'(BAUDOT_BITS));
	assign is_tune    = !(poll.op == OP_CHAR || poll.op == OP_EMPTY);
	assign is_empty   = (poll.op == OP_EMPTY);
	assign ok         = shift_state_q ? poll.in_figures : poll.in_letters;

	// classify the poll into a job for the symbol sequencer
	always_comb begin
		push_job.kind  = JOB_TONE;
		push_job.two   = 1'b0;
		push_job.code0 = CODE_NUL;
		push_job.code1 = CODE_NUL;
		push_job.taken = 1'b0;
		push       = 1'b0;
		shift_upd  = 1'b0;
		next_shift = shift_state_q;
		dec_pre    = 1'b0;
		if (is_tune) begin
			push = 1'b1;
		end else if (preamble_left_q != 8'd0) begin
			push    = 1'b1;
			dec_pre = 1'b1;
		end else if (is_empty) begin
			push = 1'b1;
			if (poll.stop_requested) begin
				push_job.kind = JOB_STOP;
			end else begin
				push_job.kind  = JOB_FRAME;
				push_job.code0 = baudot ? CODE_LETS : CODE_NUL;
				shift_upd      = 1'b1;
				next_shift     = 1'b0;
			end
		end else begin
			push_job.kind  = JOB_FRAME;
			push_job.taken = 1'b1;
			if (!baudot) begin
				push           = 1'b1;
				push_job.code0 = poll.code;
			end else if (poll.is_space) begin
				push           = 1'b1;
				push_job.two   = 1'b1;
				push_job.code0 = CODE_LETS;
				push_job.code1 = CODE_SPACE;
				shift_upd      = 1'b1;
				next_shift     = 1'b0;
			end else if (poll.in_letters || poll.in_figures) begin
				push = 1'b1;
				if (ok) begin
					push_job.code0 = {3'b000, poll.code[4:0]};
				end else begin
					push_job.two   = 1'b1;
					push_job.code0 = shift_state_q ? CODE_LETS : CODE_FIGS;
					push_job.code1 = {3'b000, poll.code[4:0]};
					shift_upd      = 1'b1;
					next_shift     = !shift_state_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_state_q   <= 1'b0;
			preamble_left_q <= 8'd0;
		end else begin
			if (accept && shift_upd)
				shift_state_q <= next_shift;
			if (pre_load)
				preamble_left_q <= pre_value;
			else if (accept && dec_pre)
				preamble_left_q <= preamble_left_q - 8'd1;
		end
	end

endmodule

// ----- src/rff_queue.sv -----
module rff_queue import rff_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output job_t head
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- src/rff_back.sv -----
module rff_back import rff_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  job_valid,
	input  job_t  job,
	output logic  pop,
	rff_out_if.source sym
);

	logic [SYM_W-1:0] k_q;
	logic             frame_q;
	logic             out_valid_q;
	logic [13:0]      tone_q;
	logic [15:0]      dur_q;
	logic             taken_q;
	logic             fin_q;
	logic             last_q;

	logic [SYM_W-1:0] nb;
	logic [7:0]       c;
	logic [7:0]       mask;
	logic             par_en;
	logic             par;
	logic             pbit;
	logic [SYM_W-1:0] stop_idx;
	logic [SYM_W-1:0] j;
	logic             mark;
	logic             eof;
	logic             sym_last;
	logic             fire;
	logic [15:0]      dur;
	logic [13:0]      tone;
	logic             mark_eff;
	logic signed [15:0] f;

	assign nb = eff_bits(cfg.data_bits);
	assign c  = frame_q ? job.code1 : job.code0;

	always_comb begin
		for (int i = 0; i < 8; i++)
			mask[i] = (SYM_W'(i) < nb);
	end

	assign par = ^(c & mask);

	always_comb begin
		par_en = 1'b1;
		pbit   = 1'b0;
		case (cfg.parity_mode)
			PAR_EVEN: pbit = par;
			PAR_ODD:  pbit = !par;
			PAR_ZERO: pbit = 1'b0;
			PAR_ONE:  pbit = 1'b1;
			default:  par_en = 1'b0;
		endcase
	end

	assign stop_idx = nb + SYM_W'(1) + SYM_W'(par_en);
	assign j        = cfg.order_polarity[0] ? (nb - k_q) : (k_q - SYM_W'(1));

	// current symbol of the frame: start, data, parity, stop
	always_comb begin
		eof  = 1'b0;
		mark = 1'b1;
		dur  = cfg.bit_len;
		if (job.kind == JOB_FRAME) begin
			if (k_q == '0) begin
				mark = 1'b0;
			end else if (k_q <= nb) begin
				mark = c[j[2:0]];
			end else if (k_q == stop_idx) begin
				eof = 1'b1;
				dur = cfg.stop_len;
			end else begin
				mark = pbit;
			end
		end
	end

	assign sym_last = (job.kind != JOB_FRAME) || (eof && (frame_q == job.two));

	assign mark_eff = mark ^ cfg.order_polarity[1];

	always_comb begin
		f = signed'({3'b000, cfg.center_freq, 1'b0});
		if (mark_eff)
			f = f - signed'({6'd0, cfg.shift});
		else
			f = f + signed'({6'd0, cfg.shift});
		if (f < 0)
			tone = 14'd0;
		else if (f > signed'({2'b00, TONE_MAX}))
			tone = TONE_MAX;
		else
			tone = f[13:0];
	end

	assign fire = job_valid && (!out_valid_q || sym.ready);
	assign pop  = fire && sym_last;

	always_ff @(posedge clk) begin
		if (fire) begin
			taken_q <= job.taken;
			last_q  <= sym_last;
			if (job.kind == JOB_STOP) begin
				tone_q <= 14'd0;
				dur_q  <= 16'd0;
				fin_q  <= 1'b1;
			end else begin
				tone_q <= tone;
				dur_q  <= dur;
				fin_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
			frame_q     <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (sym.ready)
				out_valid_q <= 1'b0;
			if (fire) begin
				if (sym_last) begin
					k_q     <= '0;
					frame_q <= 1'b0;
				end else if (eof) begin
					k_q     <= '0;
					frame_q <= 1'b1;
				end else begin
					k_q <= k_q + SYM_W'(1);
				end
			end
		end
	end

	assign sym.valid        = out_valid_q;
	assign sym.tone_half_hz = tone_q;
	assign sym.duration     = dur_q;
	assign sym.char_taken   = taken_q;
	assign sym.finished     = fin_q;
	assign sym.last         = last_q;

endmodule

// ----- src/rtty_fsk_character_framer.sv -----
// rtty fsk character framer
// poll (sink): one transaction per transmitter poll: op, code, shift flags,
//   is_space, stop_requested. sym (source): one transaction per fsk symbol,
//   tone in half-hertz, duration in samples, char_taken, finished, and last
//   on the final symbol of a poll. cfg (sink): register writes, index 0..7,
//   always ready; write only while no poll is in flight.
// a poll is classified combinationally and queued (two entries) as a job; the
//   symbol sequencer then sends one symbol per cycle unless sym stalls. a poll
//   has 1 symbol for tune, preamble or stop, 7 to 11 for one frame and up to
//   16 for a shift or space pair. the sequencer is the limit.
// a poll's first symbol goes through the queue, then the output register; a poll
//   that gives no symbols (rejected baudot code) leaves nothing in the queue.
// reset restores the register defaults, the letters shift, a zero preamble
//   count and empty queue and output register.
// when sym stalls the output register holds, the sequencer waits and the
//   queue fills; poll.ready drops only with two jobs waiting.
module rtty_fsk_character_framer import rff_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rff_in_if.sink     poll,
	rff_out_if.source  sym,
	rff_cfg_if.sink    cfg
);

	cfg_t cfg_q;
	logic pre_load;
	logic q_full;
	logic q_push;
	job_t q_push_job;
	logic q_pop;
	logic q_not_empty;
	job_t q_head;

	assign cfg.ready = 1'b1;
	assign pre_load  = cfg.valid && (reg_idx_t'(cfg.index) == REG_PREAMBLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_bits      <= 4'd5;
			cfg_q.order_polarity <= 2'd0;
			cfg_q.parity_mode    <= 3'd0;
			cfg_q.preamble_len   <= 8'd0;
			cfg_q.bit_len        <= 16'd176;
			cfg_q.stop_len       <= 16'd264;
			cfg_q.center_freq    <= 12'd1000;
			cfg_q.shift          <= 10'd170;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_DATA_BITS:   cfg_q.data_bits      <= cfg.data[3:0];
				REG_ORDER_POL:   cfg_q.order_polarity <= cfg.data[1:0];
				REG_PARITY_MODE: cfg_q.parity_mode    <= cfg.data[2:0];
				REG_PREAMBLE:    cfg_q.preamble_len   <= cfg.data[7:0];
				REG_BIT_LEN:     cfg_q.bit_len        <= cfg.data;
				REG_STOP_LEN:    cfg_q.stop_len       <= cfg.data;
				REG_CENTER_FREQ: cfg_q.center_freq    <= cfg.data[11:0];
				REG_SHIFT:       cfg_q.shift          <= cfg.data[9:0];
				default:         cfg_q.data_bits      <= cfg_q.data_bits;
			endcase
		end
	end

	rff_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pre_load  (pre_load),
		.pre_value (cfg.data[7:0]),
		.q_full    (q_full),
		.poll      (poll),
		.push      (q_push),
		.push_job  (q_push_job)
	);

	rff_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push && poll.valid),
		.push_job  (q_push_job),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	rff_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_not_empty),
		.job       (q_head),
		.pop       (q_pop),
		.sym       (sym)
	);

endmodule

// ----- bench/testbench.sv -----
module testbench import rff_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int MAX_SYMBOLS = 16;
	localparam int MAX_GAP = 100;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 2000;
	localparam int RANDOM_PHASE_ITEMS = 20;
	localparam int PRESSURE_ITEMS = 16;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] code;
		logic       in_letters;
		logic       in_figures;
		logic       is_space;
		logic       stop_requested;
	} poll_item_t;

	typedef struct packed {
		logic [13:0] tone_half_hz;
		logic [15:0] duration;
		logic        char_taken;
		logic        finished;
		logic        last;
	} symbol_t;

	class symbol_scoreboard;
		logic [3:0]  data_bits;
		logic [1:0]  order_polarity;
		logic [2:0]  parity_mode;
		logic [7:0]  preamble_len;
		logic [15:0] bit_len;
		logic [15:0] stop_len;
		logic [11:0] center_freq;
		logic [9:0]  shift;
		bit          figures_shift;
		logic [7:0]  preamble_left;
		bit          taken;
		symbol_t     poll_symbols[$];
		symbol_t     pending_symbols[$];
		int          errors;
		int          polls_seen;
		int          symbols_checked;
		int          reg_writes;

		function new();
			data_bits = 5;
			order_polarity = 0;
			parity_mode = PAR_NONE;
			preamble_len = 0;
			bit_len = 176;
			stop_len = 264;
			center_freq = 1000;
			shift = 170;
			figures_shift = 0;
			preamble_left = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] d);
			case (idx)
				REG_DATA_BITS:   data_bits = d[3:0];
				REG_ORDER_POL:   order_polarity = d[1:0];
				REG_PARITY_MODE: parity_mode = d[2:0];
				REG_PREAMBLE: begin
					preamble_len = d[7:0];
					preamble_left = d[7:0];
				end
				REG_BIT_LEN:     bit_len = d;
				REG_STOP_LEN:    stop_len = d;
				REG_CENTER_FREQ: center_freq = d[11:0];
				REG_SHIFT:       shift = d[9:0];
				default: ;
			endcase
			reg_writes++;
		endfunction

		function int frame_bits();
			if (data_bits < BAUDOT_BITS)
				return BAUDOT_BITS;
			if (data_bits > MAX_DATA_BITS)
				return MAX_DATA_BITS;
			return data_bits;
		endfunction

		function void add_tone(bit mark, logic [15:0] dur);
			int f;
			symbol_t s;
			if (order_polarity[1])
				mark = !mark;
			f = 2 * int'(center_freq);
			f = mark ? f - int'(shift) : f + int'(shift);
			if (f < 0)
				f = 0;
			if (f > int'(TONE_MAX))
				f = int'(TONE_MAX);
			s.tone_half_hz = 14'(f);
			s.duration = dur;
			s.char_taken = taken;
			s.finished = 0;
			s.last = 0;
			if (poll_symbols.size() < MAX_SYMBOLS)
				poll_symbols.push_back(s);
		endfunction

		function void add_frame(logic [7:0] c);
			int nbits;
			int j;
			bit par;
			nbits = frame_bits();
			par = 0;
			add_tone(0, bit_len);
			for (int i = 0; i < nbits; i++) begin
				j = order_polarity[0] ? nbits - 1 - i : i;
				par ^= c[j];
				add_tone(c[j], bit_len);
			end
			case (parity_mode)
				PAR_EVEN: add_tone(par, bit_len);
				PAR_ODD:  add_tone(!par, bit_len);
				PAR_ZERO: add_tone(0, bit_len);
				PAR_ONE:  add_tone(1, bit_len);
				default: ;
			endcase
			add_tone(1, stop_len);
		endfunction

		function void note_poll(poll_item_t p);
			bit baudot;
			symbol_t s;
			baudot = frame_bits() == BAUDOT_BITS;
			poll_symbols.delete();
			taken = 0;
			polls_seen++;
			if (p.op != OP_CHAR && p.op != OP_EMPTY) begin
				add_tone(1, bit_len);
			end else if (preamble_left != 0) begin
				add_tone(1, bit_len);
				preamble_left--;
			end else if (p.op == OP_EMPTY) begin
				if (p.stop_requested) begin
					s = '0;
					s.finished = 1;
					poll_symbols.push_back(s);
				end else begin
					add_frame(baudot ? CODE_LETS : CODE_NUL);
					figures_shift = 0;
				end
			end else begin
				taken = 1;
				if (!baudot) begin
					add_frame(p.code);
				end else if (p.is_space) begin
					// unshift-on-space
					add_frame(CODE_LETS);
					add_frame(CODE_SPACE);
					figures_shift = 0;
				end else if (p.in_letters || p.in_figures) begin
					if (figures_shift ? !p.in_figures : !p.in_letters) begin
						add_frame(figures_shift ? CODE_LETS : CODE_FIGS);
						figures_shift = !figures_shift;
					end
					add_frame({3'b000, p.code[4:0]});
				end
			end
			if (poll_symbols.size() > 0)
				poll_symbols[poll_symbols.size() - 1].last = 1;
			foreach (poll_symbols[i])
				pending_symbols.push_back(poll_symbols[i]);
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			errors++;
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_symbol(symbol_t got);
			symbol_t want;
			if (pending_symbols.size() == 0) begin
				errors++;
				$display("%0t unexpected symbol: expected none, actual tone %0d duration %0d",
					$time, got.tone_half_hz, got.duration);
				return;
			end
			want = pending_symbols.pop_front();
			symbols_checked++;
			if (got.tone_half_hz !== want.tone_half_hz)
				report("tone_half_hz", want.tone_half_hz, got.tone_half_hz);
			if (got.duration !== want.duration)
				report("duration", want.duration, got.duration);
			if (got.char_taken !== want.char_taken)
				report("char_taken", want.char_taken, got.char_taken);
			if (got.finished !== want.finished)
				report("finished", want.finished, got.finished);
			if (got.last !== want.last)
				report("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rff_in_if  poll();
	rff_out_if sym();
	rff_cfg_if cfg();

	rtty_fsk_character_framer uut (
		.clk(clk),
		.arst_n(arst_n),
		.poll(poll),
		.sym(sym),
		.cfg(cfg)
	);

	symbol_scoreboard board = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 0;
	int settings_used = 0;
	int stuck_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: checks each symbol transaction and drives ready
	initial begin
		symbol_t got;
		int hold_left;
		hold_left = 0;
		sym.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && sym.valid && sym.ready) begin
				got = '{sym.tone_half_hz, sym.duration, sym.char_taken, sym.finished, sym.last};
				board.check_symbol(got);
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				sym.ready <= 1'b0;
			end else begin
				sym.ready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (poll.valid && poll.ready) || (sym.valid && sym.ready)
				|| (cfg.valid && cfg.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t no transaction for %0d cycles", $time, STUCK_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic poll_item_t make_poll(logic [1:0] op, logic [7:0] code, bit letters,
			bit figures, bit space, bit stop);
		poll_item_t p;
		p.op = op;
		p.code = code;
		p.in_letters = letters;
		p.in_figures = figures;
		p.is_space = space;
		p.stop_requested = stop;
		return p;
	endfunction

	function automatic poll_item_t random_poll();
		poll_item_t p;
		int r;
		r = $urandom_range(99);
		p.op = r < 60 ? OP_CHAR : r < 75 ? OP_EMPTY : r < 92 ? OP_TUNE : OP_UNUSED;
		p.code = 8'($urandom_range(255));
		r = $urandom_range(99);
		p.in_letters = r < 40 || (r >= 70 && r < 90);
		p.in_figures = r >= 40 && r < 90;
		p.is_space = $urandom_range(99) < 10;
		p.stop_requested = $urandom_range(99) < 30;
		return p;
	endfunction

	task automatic send_poll(poll_item_t p);
		int gap;
		poll.valid <= 1'b1;
		poll.op <= p.op;
		poll.code <= p.code;
		poll.in_letters <= p.in_letters;
		poll.in_figures <= p.in_figures;
		poll.is_space <= p.is_space;
		poll.stop_requested <= p.stop_requested;
		@(posedge clk);
		while (!poll.ready)
			@(posedge clk);
		board.note_poll(p);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			poll.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// a rejected code leaves no symbol behind, so give the block a few cycles to finish
	task automatic drain();
		poll.valid <= 1'b0;
		while (board.pending_symbols.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		board.write_reg(idx, d);
	endtask

	task automatic configure(cfg_t c);
		drain();
		write_reg(REG_DATA_BITS, 16'(c.data_bits));
		write_reg(REG_ORDER_POL, 16'(c.order_polarity));
		write_reg(REG_PARITY_MODE, 16'(c.parity_mode));
		write_reg(REG_PREAMBLE, 16'(c.preamble_len));
		write_reg(REG_BIT_LEN, c.bit_len);
		write_reg(REG_STOP_LEN, c.stop_len);
		write_reg(REG_CENTER_FREQ, 16'(c.center_freq));
		write_reg(REG_SHIFT, 16'(c.shift));
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_setup();
		cfg_t c;
		c.data_bits = $urandom_range(99) < 45 ? 4'd5 : $urandom_range(99) < 80
			? 4'($urandom_range(6, 8)) : 4'($urandom_range(15));
		c.order_polarity = 2'($urandom_range(3));
		c.parity_mode = 3'($urandom_range(7));
		c.preamble_len = $urandom_range(99) < 60 ? 8'd0 : 8'($urandom_range(1, 3));
		c.bit_len = 16'($urandom_range(65535));
		c.stop_len = 16'($urandom_range(65535));
		c.center_freq = 12'($urandom_range(4095));
		c.shift = 10'($urandom_range(1023));
		configure(c);
	endtask

	initial begin
		int idle_plan[4][2];
		idle_plan = '{'{0, 0}, '{82, 0}, '{0, 82}, '{7, 7}};
		arst_n <= 1'b0;
		poll.valid <= 1'b0;
		poll.op <= OP_CHAR;
		poll.code <= '0;
		poll.in_letters <= 1'b0;
		poll.in_figures <= 1'b0;
		poll.is_space <= 1'b0;
		poll.stop_requested <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_DATA_BITS;
		cfg.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: baudot, letters shift
		send_poll(make_poll(OP_TUNE, 8'h00, 0, 0, 0, 0));
		send_poll(make_poll(OP_UNUSED, 8'hFF, 1, 1, 1, 1));
		send_poll(make_poll(OP_EMPTY, 8'h00, 0, 0, 0, 0));
		send_poll(make_poll(OP_EMPTY, 8'h00, 0, 0, 0, 1));
		send_poll(make_poll(OP_CHAR, 8'h03, 1, 0, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'h11, 0, 1, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'h0A, 0, 1, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'hE5, 1, 0, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'h07, 0, 0, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'h04, 0, 0, 1, 0));
		send_poll(make_poll(OP_CHAR, 8'h1F, 1, 1, 0, 0));

		// 8 bits msb-first, short preamble, saturated high tone
		configure('{data_bits: 4'd8, order_polarity: 2'd1, parity_mode: PAR_EVEN,
			preamble_len: 8'd3, bit_len: 16'd1, stop_len: 16'hFFFF,
			center_freq: 12'hFFF, shift: 10'h3FF});
		send_poll(make_poll(OP_CHAR, 8'hFF, 1, 1, 0, 0));
		send_poll(make_poll(OP_TUNE, 8'h00, 0, 0, 0, 0));
		send_poll(make_poll(OP_EMPTY, 8'h00, 0, 0, 0, 1));
		send_poll(make_poll(OP_CHAR, 8'h00, 0, 0, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'hA5, 0, 0, 1, 0));
		send_poll(make_poll(OP_EMPTY, 8'h00, 0, 0, 0, 0));

		// data_bits below range acts as baudot; tones clamp at zero
		configure('{data_bits: 4'd0, order_polarity: 2'd2, parity_mode: PAR_ODD,
			preamble_len: 8'd0, bit_len: 16'hFFFF, stop_len: 16'd1,
			center_freq: 12'd0, shift: 10'h3FF});
		send_poll(make_poll(OP_CHAR, 8'h0B, 1, 0, 0, 0));
		send_poll(make_poll(OP_CHAR, 8'hFF, 0, 1, 0, 0));

		configure('{data_bits: 4'd15, order_polarity: 2'd3, parity_mode: PAR_ZERO,
			preamble_len: 8'd0, bit_len: 16'd0, stop_len: 16'd0,
			center_freq: 12'hFFF, shift: 10'd0});
		send_poll(make_poll(OP_CHAR, 8'h81, 0, 0, 0, 0));

		configure('{data_bits: 4'd6, order_polarity: 2'd0, parity_mode: PAR_ONE,
			preamble_len: 8'd255, bit_len: 16'd176, stop_len: 16'd264,
			center_freq: 12'd1000, shift: 10'd170});
		send_poll(make_poll(OP_CHAR, 8'h3C, 1, 0, 0, 0));
		send_poll(make_poll(OP_EMPTY, 8'h00, 0, 0, 0, 0));

		for (int ph = 0; ph < 4; ph++) begin
			random_setup();
			send_idle_pct = idle_plan[ph][0];
			recv_stall_pct = idle_plan[ph][1];
			repeat (RANDOM_PHASE_ITEMS) send_poll(random_poll());
		end

		// receiver holds off while polls keep coming, so the job queue fills
		random_setup();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1;
		repeat (PRESSURE_ITEMS) send_poll(random_poll());

		drain();
		$display("covered %0d polls, %0d symbols checked, %0d register writes over %0d settings",
			board.polls_seen, board.symbols_checked, board.reg_writes, settings_used);
		$display("baudot shifts, wide frames, all parity modes, preamble, sender gaps and stalls");
		if (board.errors == 0 && board.pending_symbols.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
